// File: hw/rtl/sds_pkg.sv
// Package for the seven-segment decimal scanner.
// Holds controller state, command/status structs and the segment lookup.
// No dependencies.
package sds_pkg;

	localparam int VALUE_W    = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int STEPS      = VALUE_W;
	localparam int STEP_W     = $clog2(STEPS);
	localparam int SEL_W      = 3;
	localparam int SEG_W      = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_STORE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic tick;
		logic shift;
		logic store;
	} ctrl_cmd_t;

	// datapath/ports -> controller
	typedef struct packed {
		logic item_valid;
		logic action;
		logic out_busy;
	} ctrl_sts_t;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// segment code, bit0 = a .. bit6 = g, point always off
	function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
		logic [SEG_W-1:0] c;
		case (d)
			4'd0: c = 8'h3F;
			4'd1: c = 8'h06;
			4'd2: c = 8'h5B;
			4'd3: c = 8'h4F;
			4'd4: c = 8'h66;
			4'd5: c = 8'h6D;
			4'd6: c = 8'h7D;
			4'd7: c = 8'h07;
			4'd8: c = 8'h7F;
			4'd9: c = 8'h6F;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: hw/rtl/sds_if.sv
// Valid/ready channel interfaces for the input items and the scan results.
// Depends on sds_pkg for field widths.
interface sds_in_if import sds_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               action;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

interface sds_out_if import sds_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEL_W-1:0] digit_select;
	logic [SEG_W-1:0] segments;
	logic             overflow;

	modport source (output valid, output digit_select, output segments, output overflow,
		input ready);
	modport sink   (input valid, input digit_select, input segments, input overflow,
		output ready);
endinterface

// File: hw/rtl/seven_segment_decimal_scanner.sv
// Top level of the seven-segment decimal scanner: controller plus datapath.
// Depends on sds_pkg, sds_if, sds_ctrl, sds_dpath.
//
//  channel  dir  payload                               beat per
//  item     in   action, value[31:0]                   load or tick
//  disp     out  digit_select[2:0], segments[7:0], overflow   tick
//
// A tick's result sits in an output register, so
// ticks go back to back while the sink keeps up.
// A load runs in order: accept, 32 shift-add-3 steps, one store of all codes.
// No item is taken during a load, nor while the result register is full and stalled.
// Reset clears the codes (display blank), scan position and overflow flag.
module seven_segment_decimal_scanner import sds_pkg::*; #(
	parameter int NUM_DIGITS = 8
) (
	input logic       clk,
	input logic       arst_n,
	sds_in_if.sink    item,
	sds_out_if.source disp
);

	ctrl_sts_t sts;
	ctrl_cmd_t cmd;

	assign sts.item_valid = item.valid;
	assign sts.action     = item.action;
	assign sts.out_busy   = disp.valid && !disp.ready;

	sds_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.sts        (sts),
		.cmd        (cmd),
		.item_ready (item.ready)
	);

	sds_dpath #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (item.value),
		.out_ready    (disp.ready),
		.out_valid    (disp.valid),
		.digit_select (disp.digit_select),
		.segments     (disp.segments),
		.overflow     (disp.overflow)
	);

endmodule

// File: hw/rtl/sds_ctrl.sv
// Controller: sequences the double-dabble conversion and gates input beats.
// Depends on sds_pkg.
module sds_ctrl import sds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd,
	output logic      item_ready
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] cnt_q;
	logic              last_step;

	assign last_step = (cnt_q == STEP_W'(STEPS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load)
					state_d = ST_CONV;
			end
			ST_CONV: begin
				if (last_step)
					state_d = ST_STORE;
			end
			ST_STORE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				item_ready = !sts.out_busy;
				cmd.load   = sts.item_valid && !sts.out_busy && (sts.action == ACT_LOAD);
				cmd.tick   = sts.item_valid && !sts.out_busy && (sts.action == ACT_TICK);
			end
			ST_CONV:  cmd.shift = 1'b1;
			ST_STORE: cmd.store = 1'b1;
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				cnt_q <= '0;
			else if (cmd.shift)
				cnt_q <= cnt_q + STEP_W'(1);
		end
	end

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_CONV) && (cnt_q == '0))
		else $error("conversion did not start after load");

	a_store_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) && last_step |=> (state_q == ST_STORE))
		else $error("store did not follow last shift");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !item_ready)
		else $error("input ready while converting");

endmodule

// File: hw/rtl/sds_dpath.sv
// Datapath: shift-add-3 converter, digit code buffer, scan position and
// result register. Depends on sds_pkg.
module sds_dpath import sds_pkg::*; #(
	parameter int NUM_DIGITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	input  logic [VALUE_W-1:0] value,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [SEL_W-1:0]   digit_select,
	output logic [SEG_W-1:0]   segments,
	output logic               overflow
);

	localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	logic [VALUE_W-1:0]   bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     bcd_adj;
	logic [SEG_W-1:0]     codes_q [NUM_DIGITS];
	logic [SEG_W-1:0]     codes_d [NUM_DIGITS];
	logic [BCD_DIGITS-1:0] lead_zero;  // digit k and all above are zero
	logic                 ovf_d;
	logic                 ovf_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W+SEL_W-1:0] pos_ext;
	logic                 out_valid_q;
	logic [SEL_W-1:0]     sel_q;
	logic [SEG_W-1:0]     seg_q;
	logic                 ovf_out_q;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	always_comb begin
		lead_zero[BCD_DIGITS-1] = (bcd_q[BCD_W-1 -: 4] == 4'd0);
		for (int k = BCD_DIGITS - 2; k >= 0; k--)
			lead_zero[k] = lead_zero[k+1] && (bcd_q[4*k +: 4] == 4'd0);
	end

	// rightmost position holds digit 0; blank above the top nonzero digit
	always_comb begin
		ovf_d = 1'b0;
		for (int i = NUM_DIGITS; i < BCD_DIGITS; i++)
			ovf_d = ovf_d || (bcd_q[4*i +: 4] != 4'd0);
		for (int p = 0; p < NUM_DIGITS; p++) begin
			if ((NUM_DIGITS - 1 - p) > 0 && lead_zero[NUM_DIGITS - 1 - p])
				codes_d[p] = '0;
			else
				codes_d[p] = seg_code(bcd_q[4*(NUM_DIGITS - 1 - p) +: 4]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cmd.shift) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_DIGITS; p++)
				codes_q[p] <= '0;
			ovf_q       <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				for (int p = 0; p < NUM_DIGITS; p++)
					codes_q[p] <= codes_d[p];
				ovf_q <= ovf_d;
			end
			if (cmd.tick) begin
				out_valid_q <= 1'b1;
				if (pos_q == POS_W'(NUM_DIGITS - 1))
					pos_q <= '0;
				else
					pos_q <= pos_q + POS_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pos_ext = {{SEL_W{1'b0}}, pos_q};

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			sel_q     <= pos_ext[SEL_W-1:0];
			seg_q     <= codes_q[pos_q];
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign digit_select = sel_q;
	assign segments     = seg_q;
	assign overflow     = ovf_out_q;

	a_tick_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |=> out_valid_q && (sel_q == $past(pos_ext[SEL_W-1:0])))
		else $error("tick beat not presented");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(NUM_DIGITS - 1))
		else $error("scan position out of range");

	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(sel_q) && $stable(seg_q)
			&& $stable(ovf_out_q))
		else $error("display beat changed while stalled");

endmodule
